@@ sv/bgd_pkg.sv @@
package bgd_pkg;

    // Phase of the gesture tracker; codes above PH_PRESSED act as PH_UP.
    typedef enum logic [2:0] {
        PH_UP          = 3'd0,
        PH_DOWN        = 3'd1,
        PH_FIRST_UP    = 3'd2,
        PH_SECOND_DOWN = 3'd3,
        PH_PRESSED     = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        EV_UP        = 3'd0,
        EV_CLICK     = 3'd1,
        EV_DBLCLICK  = 3'd2,
        EV_LONG      = 3'd3,
        EV_PRESS_END = 3'd4
    } t_event;

    // Config register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CLICK_MS        = 2'd0,
        REG_PRESS_MS        = 2'd1,
        REG_PRESS_REPEAT_MS = 2'd2,
        REG_DEBOUNCE_MS     = 2'd3
    } t_reg_idx;

    localparam int TIME_W = 32;
    localparam int CFG_W  = 16;
    localparam int CNT_W  = 16;
    localparam int CODE_W = 3;

    localparam logic [CFG_W-1:0] CLICK_MS_RST        = 16'd600;
    localparam logic [CFG_W-1:0] PRESS_MS_RST        = 16'd1000;
    localparam logic [CFG_W-1:0] PRESS_REPEAT_MS_RST = 16'd1000;
    localparam logic [CFG_W-1:0] DEBOUNCE_MS_RST     = 16'd50;

    // Default depth of the result queue; must be at least two.
    localparam int EVQ_DEPTH_DEF = 4;

    typedef struct packed {
        logic [CFG_W-1:0] click_ms;
        logic [CFG_W-1:0] press_ms;
        logic [CFG_W-1:0] press_repeat_ms;
        logic [CFG_W-1:0] debounce_ms;
    } t_cfg;

    typedef struct packed {
        t_event            code;
        logic [CNT_W-1:0]  press_count;
        logic [TIME_W-1:0] duration_ms;
        logic              last;
    } t_result;

    // Up to two results per tick, pushed into the queue together.
    typedef struct packed {
        logic [1:0] cnt;
        t_result    ev0;
        t_result    ev1;
    } t_push;

endpackage

@@ sv/bgd_ifs.sv @@
interface bgd_in_if import bgd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] time_ms;
    logic              button_down;

    modport source (output valid, time_ms, button_down, input ready);
    modport sink   (input valid, time_ms, button_down, output ready);
endinterface

interface bgd_out_if import bgd_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] event_code;
    logic [CNT_W-1:0]  press_count;
    logic [TIME_W-1:0] duration_ms;
    logic              last;

    modport source (output valid, event_code, press_count, duration_ms, last, input ready);
    modport sink   (input valid, event_code, press_count, duration_ms, last, output ready);
endinterface

interface bgd_cfg_if import bgd_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/bgd_cfg.sv @@
module bgd_cfg import bgd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    bgd_cfg_if.sink i_cfg,
    output t_cfg o_cfg
);

    t_cfg r_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.click_ms        <= CLICK_MS_RST;
            r_cfg.press_ms        <= PRESS_MS_RST;
            r_cfg.press_repeat_ms <= PRESS_REPEAT_MS_RST;
            r_cfg.debounce_ms     <= DEBOUNCE_MS_RST;
        end else if (i_cfg.valid) begin
            unique case (t_reg_idx'(i_cfg.index))
                REG_CLICK_MS:        r_cfg.click_ms        <= i_cfg.data;
                REG_PRESS_MS:        r_cfg.press_ms        <= i_cfg.data;
                REG_PRESS_REPEAT_MS: r_cfg.press_repeat_ms <= i_cfg.data;
                REG_DEBOUNCE_MS:     r_cfg.debounce_ms     <= i_cfg.data;
                default:             r_cfg                 <= r_cfg;
            endcase
        end
    end

endmodule

@@ sv/bgd_step.sv @@
module bgd_step import bgd_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    bgd_in_if.sink i_in,
    input  t_cfg   i_cfg,
    input  logic   i_room,
    output t_push  o_push
);

    // Input register
    logic              r_tick_valid;
    logic [TIME_W-1:0] r_time;
    logic              r_down;

    // Tracker state
    t_phase            r_phase,  n_phase;
    logic [TIME_W-1:0] r_start,  n_start;
    logic [TIME_W-1:0] r_stop,   n_stop;
    logic [CNT_W-1:0]  r_count,  n_count;

    logic              fire;
    logic [TIME_W-1:0] since_start;
    logic [TIME_W-1:0] since_stop;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] debounce_x;
    logic [1:0]        ev_cnt;
    t_event            code0;
    logic [CNT_W-1:0]  cnt0;
    logic [TIME_W-1:0] dur0;

    assign fire       = r_tick_valid && i_room;
    assign i_in.ready = !r_tick_valid || i_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_tick_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_time <= i_in.time_ms;
            r_down <= i_in.button_down;
        end
    end

    assign since_start = r_time - r_start;
    assign since_stop  = r_time - r_stop;
    assign held        = r_stop - r_start;
    assign debounce_x  = TIME_W'(i_cfg.debounce_ms);

    always_comb begin
        n_phase = r_phase;
        n_start = r_start;
        n_stop  = r_stop;
        n_count = r_count;
        ev_cnt  = 2'd0;
        code0   = EV_UP;
        cnt0    = r_count;
        dur0    = since_start;

        unique case (r_phase)
            PH_DOWN: begin
                if (!r_down) begin
                    if ((i_cfg.debounce_ms != '0) && (since_start < debounce_x)) begin
                        n_phase = PH_UP;
                        n_start = '0;
                        n_stop  = '0;
                        n_count = '0;
                    end else begin
                        n_phase = PH_FIRST_UP;
                        n_stop  = r_time;
                        ev_cnt  = 2'd1;
                        code0   = EV_UP;
                    end
                end else if (since_start > TIME_W'(i_cfg.press_ms)) begin
                    n_phase = PH_PRESSED;
                    n_stop  = r_time;
                    n_count = CNT_W'(1);
                    ev_cnt  = 2'd1;
                    code0   = EV_LONG;
                    cnt0    = CNT_W'(1);
                end
            end
            PH_FIRST_UP: begin
                if (since_start > TIME_W'(i_cfg.click_ms)) begin
                    // timeout: up then click, both with the stored press length
                    ev_cnt  = 2'd2;
                    code0   = EV_UP;
                    dur0    = held;
                    n_phase = PH_UP;
                    n_start = '0;
                    n_stop  = '0;
                    n_count = '0;
                end else if (r_down &&
                             ((i_cfg.debounce_ms == '0) || (since_stop > debounce_x))) begin
                    n_phase = PH_SECOND_DOWN;
                    n_start = r_time;
                end
            end
            PH_SECOND_DOWN: begin
                if (!r_down && (since_start > debounce_x)) begin
                    ev_cnt  = 2'd1;
                    code0   = EV_DBLCLICK;
                    n_phase = PH_UP;
                    n_start = '0;
                    n_stop  = '0;
                    n_count = '0;
                end
            end
            PH_PRESSED: begin
                if (!r_down) begin
                    ev_cnt  = 2'd1;
                    code0   = EV_PRESS_END;
                    n_phase = PH_UP;
                    n_start = '0;
                    n_stop  = '0;
                    n_count = '0;
                end else if ((i_cfg.press_repeat_ms != '0) &&
                             (since_stop >= TIME_W'(i_cfg.press_repeat_ms))) begin
                    n_stop  = r_time;
                    n_count = (r_count == '1) ? r_count : r_count + CNT_W'(1);
                    ev_cnt  = 2'd1;
                    code0   = EV_LONG;
                    cnt0    = n_count;
                end
            end
            default: begin
                // up, and any stray code
                if (r_down) begin
                    n_phase = PH_DOWN;
                    n_start = r_time;
                end else begin
                    n_phase = PH_UP;
                end
            end
        endcase
    end

    always_comb begin
        o_push.cnt             = fire ? ev_cnt : 2'd0;
        o_push.ev0.code        = code0;
        o_push.ev0.press_count = cnt0;
        o_push.ev0.duration_ms = dur0;
        o_push.ev0.last        = (ev_cnt == 2'd1);
        o_push.ev1.code        = EV_CLICK;
        o_push.ev1.press_count = r_count;
        o_push.ev1.duration_ms = held;
        o_push.ev1.last        = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_UP;
            r_start <= '0;
            r_stop  <= '0;
            r_count <= '0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_start <= n_start;
            r_stop  <= n_stop;
            r_count <= n_count;
        end
    end

    // A tick with two results is always the click timeout, which restarts.
    a_two_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push.cnt == 2'd2) |=> (r_phase == PH_UP && r_count == '0))
        else $error("two results without restart");

    // Long press from down always starts the repeat count at one.
    a_long_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && r_phase == PH_DOWN && o_push.cnt == 2'd1 && code0 == EV_LONG)
        |=> (r_phase == PH_PRESSED && r_count == CNT_W'(1)))
        else $error("long press entry lost count");

endmodule

@@ sv/bgd_evq.sv @@
module bgd_evq import bgd_pkg::*; #(
    parameter int DEPTH = EVQ_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_room,
    bgd_out_if.source o_out
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int QCNT_W = $clog2(DEPTH + 1);

    t_result           mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    logic [PTR_W-1:0]  wr_ptr1;
    logic              pop;
    t_result           head;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Room for the worst case of two results from the next tick
    assign o_room = (r_count <= QCNT_W'(DEPTH - 2));

    assign head              = mem[r_rd_ptr];
    assign o_out.valid       = (r_count != '0);
    assign o_out.event_code  = head.code;
    assign o_out.press_count = head.press_count;
    assign o_out.duration_ms = head.duration_ms;
    assign o_out.last        = head.last;
    assign pop               = o_out.valid && o_out.ready;
    assign wr_ptr1           = ptr_inc(r_wr_ptr);

    always_comb begin
        n_rd_ptr = pop ? ptr_inc(r_rd_ptr) : r_rd_ptr;
        unique case (i_push.cnt)
            2'd1:    n_wr_ptr = wr_ptr1;
            2'd2:    n_wr_ptr = ptr_inc(wr_ptr1);
            default: n_wr_ptr = r_wr_ptr;
        endcase
        n_count = r_count + QCNT_W'(i_push.cnt) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            mem[r_wr_ptr] <= i_push.ev0;
        end
        if (i_push.cnt == 2'd2) begin
            mem[wr_ptr1] <= i_push.ev1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.cnt != 2'd0) |-> o_room)
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(DEPTH))
        else $error("result queue count out of range");

endmodule

@@ sv/button_gesture_detector_core.sv @@
// Channel  | Dir | Words carried                                  | Handshake
// ---------+-----+------------------------------------------------+-----------
// i_in     | in  | time_ms[31:0], button_down                     | valid/ready
// o_out    | out | event_code[2:0], press_count[15:0],            | valid/ready
//          |     | duration_ms[31:0], last                        |
// i_cfg    | in  | index[1:0] (0 click, 1 press, 2 repeat,        | valid/ready
//          |     | 3 debounce), data[15:0]                        |
//
// One tick word per cycle while the queue has room: the tick is registered,
// the phase logic works on the registered tick and pushes its results into
// a small result queue, whose head is presented on o_out.
// A tick retires only while the queue has room for two; stalls need o_out backpressure.
// Synchronous active-low reset: phase up, stamps and count zero, config
// back to 600/1000/1000/50 ms, queue empty. Config is always ready.
module button_gesture_detector_core import bgd_pkg::*; #(
    parameter int EVQ_DEPTH = EVQ_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    bgd_in_if.sink    i_in,
    bgd_out_if.source o_out,
    bgd_cfg_if.sink   i_cfg
);

    t_cfg  cfg;     // current thresholds
    t_push push;    // results of the tick in flight
    logic  room;    // queue can take a full tick's worth of results

    // Config register file
    bgd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // Input register plus phase tracker; one tick retires per cycle when
    // the queue has room.
    bgd_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (cfg),
        .i_room  (room),
        .o_push  (push)
    );

    // Result queue, drained one word per cycle on o_out while o_out.ready is high
    bgd_evq #(
        .DEPTH (EVQ_DEPTH)
    ) u_evq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule
